/* rtl/ifm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifm_pkg
// Shared constants and types for the instruction forecast monitor.
// ----------------------------------------------------------------------------
package ifm_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned MaxResults   = 16;
  localparam int unsigned IdxW         = $clog2(TableEntries + 1);

  localparam logic [1:0] OP_FORECAST = 2'd0;
  localparam logic [1:0] OP_EXEC     = 2'd1;
  localparam logic [1:0] OP_TERM     = 2'd2;

  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

  // Per-entry contents
  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic [3:0]  cls;
    logic [47:0] ftime;
    logic [47:0] fgap;
    logic [47:0] ltime;
    logic [47:0] gsum;
    logic [31:0] cnt;
  } entry_t;

  // Command passed from cell to cell
  typedef struct packed {
    logic        act;     // command is live
    logic [1:0]  op;
    logic [31:0] addr;
    logic [3:0]  cls;
    logic [47:0] now;
    logic        found;   // forecast: address already matched upstream
    logic        taken;   // forecast: free slot already taken upstream
  } cmd_t;

endpackage

/* rtl/instruction_forecast_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// instruction_forecast_monitor
// Forecast table as a chain of entry cells with a termination reporter.
// ----------------------------------------------------------------------------
// Forecast/execution: the command ripples down the cell chain, one pass
// through all TableEntries cells; a forecast that misses the table takes a
// second pass. Termination: a scan of the entries, plus a division for each
// matching entry with executions. Results are strobed one cycle each; the
// receiver cannot stall. Synchronous active-low reset marks all entries
// invalid.
// ----------------------------------------------------------------------------
module instruction_forecast_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_code_address,
  input  logic [3:0]  in_instr_class,
  input  logic [47:0] in_cycle_now,
  output logic        out_valid,
  output logic        out_status,
  output logic [31:0] out_entry_address,
  output logic [31:0] out_exec_total,
  output logic [47:0] out_first_delay,
  output logic [47:0] out_mean_gap,
  output logic        out_last_of_run
);

  localparam int unsigned N = ifm_pkg::TableEntries;
  localparam logic [2:0] S_IDLE = 3'd0, S_P1 = 3'd1, S_P2 = 3'd2, S_SCAN = 3'd3,
                         S_DIV = 3'd4;

  ifm_pkg::cmd_t   chain [N+1];
  ifm_pkg::entry_t ents  [N];
  ifm_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [2:0]      st_r, st_nxt;
  logic            pass2_r, pass2_nxt;
  logic [ifm_pkg::IdxW-1:0] idx_r, idx_nxt;
  logic [ifm_pkg::IdxW-1:0] cur_r, cur_nxt;
  logic            have_r, have_nxt;
  logic [47:0]     mg_r, mg_nxt;
  logic            kick_r;
  logic            ddone;
  logic [47:0]     quo;
  logic            match;
  ifm_pkg::entry_t e_idx, e_cur;
  logic            inj;

  assign chain[0] = inj ? cmd_r : '0;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      ifm_cell u_cell (
        .clk(clk), .rst_n(rst_n), .pass2(pass2_r),
        .cmd_in(chain[g]), .cmd_out(chain[g+1]), .ent(ents[g])
      );
    end
  endgenerate

  assign e_idx = ents[idx_r[$clog2(N)-1:0]];
  assign e_cur = ents[cur_r[$clog2(N)-1:0]];
  assign match = (idx_r < ifm_pkg::IdxW'(N)) && e_idx.valid && (e_idx.cls == cmd_r.cls);

  // divider starts in the cycle after selection, once cur_r points at the entry
  ifm_div u_div (
    .clk(clk), .rst_n(rst_n), .go(kick_r), .dividend(e_cur.gsum), .divisor(e_cur.cnt),
    .done(ddone), .quotient(quo)
  );

  // sequencer
  always_comb begin
    st_nxt    = st_r;
    cmd_nxt   = cmd_r;
    pass2_nxt = pass2_r;
    idx_nxt   = idx_r;
    cur_nxt   = cur_r;
    have_nxt  = have_r;
    mg_nxt    = mg_r;
    inj       = 1'b0;
    out_valid = 1'b0;
    out_status = 1'b0;
    out_entry_address = e_cur.addr;
    out_exec_total = e_cur.cnt;
    out_first_delay = e_cur.fgap;
    out_mean_gap = mg_r;
    out_last_of_run = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt.act   = 1'b1;
          cmd_nxt.op    = in_operation;
          cmd_nxt.addr  = in_code_address;
          cmd_nxt.cls   = in_instr_class;
          cmd_nxt.now   = in_cycle_now;
          cmd_nxt.found = 1'b0;
          cmd_nxt.taken = 1'b0;
          pass2_nxt     = 1'b0;
          idx_nxt       = '0;
          have_nxt      = 1'b0;
          if (in_operation == ifm_pkg::OP_TERM) st_nxt = S_SCAN;
          else if (in_operation inside {ifm_pkg::OP_FORECAST, ifm_pkg::OP_EXEC})
            st_nxt = S_P1;
          else st_nxt = S_IDLE;
        end
      end
      S_P1, S_P2: begin
        if (idx_r == '0) inj = 1'b1;
        idx_nxt = idx_r + ifm_pkg::IdxW'(1);
        if (idx_r == ifm_pkg::IdxW'(N)) begin
          idx_nxt = '0;
          if (st_r == S_P1 && cmd_r.op == ifm_pkg::OP_FORECAST && !chain[N].found) begin
            st_nxt    = S_P2;
            pass2_nxt = 1'b1;
          end else begin
            st_nxt = S_IDLE;
            if (st_r == S_P2 && !chain[N].taken) begin
              out_valid = 1'b1;
              out_status = 1'b1;
              out_entry_address = cmd_r.addr;
              out_exec_total = '0;
              out_first_delay = '0;
              out_mean_gap = '0;
              out_last_of_run = 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        // find next match; emit previous one once the next is known
        if (match || idx_r == ifm_pkg::IdxW'(N)) begin
          if (have_r) begin
            out_valid = 1'b1;
            out_last_of_run = !match;
          end
          if (match) begin
            cur_nxt  = idx_r;
            have_nxt = 1'b1;
            st_nxt   = S_DIV;
            idx_nxt  = idx_r + ifm_pkg::IdxW'(1);
          end else st_nxt = S_IDLE;
        end else idx_nxt = idx_r + ifm_pkg::IdxW'(1);
        if (st_nxt == S_DIV && ents[idx_r[$clog2(N)-1:0]].cnt == '0) begin
          mg_nxt = '0;
          st_nxt = S_SCAN;
        end
      end
      S_DIV: begin
        if (ddone) begin
          mg_nxt = quo;
          st_nxt = S_SCAN;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      have_r <= 1'b0;
      kick_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      have_r <= have_nxt;
      kick_r <= (st_r == S_SCAN) && (st_nxt == S_DIV);
    end
    cmd_r   <= cmd_nxt;
    pass2_r <= pass2_nxt;
    idx_r   <= idx_nxt;
    cur_r   <= cur_nxt;
    mg_r    <= mg_nxt;
  end

  assign busy = (st_r != S_IDLE);

endmodule

/* rtl/ifm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifm_cell
// One table entry. Applies the passing command and hands it on, registered.
// Forecast allocation relies on a first pass (found scan) and a second pass.
// ----------------------------------------------------------------------------
module ifm_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pass2,      // forecast second pass: allocate
  input  ifm_pkg::cmd_t   cmd_in,
  output ifm_pkg::cmd_t   cmd_out,
  output ifm_pkg::entry_t ent
);

  ifm_pkg::entry_t ent_r, ent_nxt;
  ifm_pkg::cmd_t   cmd_r, cmd_nxt;
  logic            hit;
  logic [47:0]     dgap;
  logic [48:0]     ssum;

  assign hit  = ent_r.valid && (ent_r.addr == cmd_in.addr);
  assign dgap = cmd_in.now - ent_r.ltime + 48'd1;
  assign ssum = {1'b0, ent_r.gsum} + {1'b0, dgap};

  // entry update
  always_comb begin
    ent_nxt = ent_r;
    cmd_nxt = cmd_in;
    if (cmd_in.act) begin
      case (cmd_in.op)
        ifm_pkg::OP_FORECAST: begin
          if (!pass2) begin
            if (hit && !cmd_in.found) begin
              cmd_nxt.found = 1'b1;
              ent_nxt.ftime = cmd_in.now;
              ent_nxt.fgap  = '0;
              ent_nxt.ltime = '0;
              ent_nxt.gsum  = '0;
              ent_nxt.cnt   = '0;
            end
          end else if (!ent_r.valid && !cmd_in.taken) begin
            cmd_nxt.taken = 1'b1;
            ent_nxt.valid = 1'b1;
            ent_nxt.addr  = cmd_in.addr;
            ent_nxt.cls   = cmd_in.cls;
            ent_nxt.ftime = cmd_in.now;
            ent_nxt.fgap  = '0;
            ent_nxt.ltime = '0;
            ent_nxt.gsum  = '0;
            ent_nxt.cnt   = '0;
          end
        end
        ifm_pkg::OP_EXEC: begin
          if (ent_r.valid && ent_r.cls == cmd_in.cls) begin
            if (ent_r.fgap == '0) ent_nxt.fgap = cmd_in.now - ent_r.ftime + 48'd1;
            else ent_nxt.gsum = ssum[48] ? ifm_pkg::MAX48 : ssum[47:0];
            ent_nxt.ltime = cmd_in.now;
            if (ent_r.cnt != ifm_pkg::MAX32) ent_nxt.cnt = ent_r.cnt + 32'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
      cmd_r.act   <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
      cmd_r.act   <= cmd_nxt.act;
    end
    ent_r.addr  <= ent_nxt.addr;
    ent_r.cls   <= ent_nxt.cls;
    ent_r.ftime <= ent_nxt.ftime;
    ent_r.fgap  <= ent_nxt.fgap;
    ent_r.ltime <= ent_nxt.ltime;
    ent_r.gsum  <= ent_nxt.gsum;
    ent_r.cnt   <= ent_nxt.cnt;
    cmd_r.op    <= cmd_nxt.op;
    cmd_r.addr  <= cmd_nxt.addr;
    cmd_r.cls   <= cmd_nxt.cls;
    cmd_r.now   <= cmd_nxt.now;
    cmd_r.found <= cmd_nxt.found;
    cmd_r.taken <= cmd_nxt.taken;
  end

  assign cmd_out = cmd_r;
  assign ent     = ent_r;

endmodule

/* rtl/ifm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifm_div
// Restoring divider, 48-bit dividend by 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module ifm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic [47:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dv_r, dv_nxt;
  logic [33:0] trial;

  assign trial = {rem_r, q_r[47]} - {2'b0, dv_r};

  // one quotient bit per cycle
  always_comb begin
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    dv_nxt  = dv_r;
    done    = 1'b0;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = 6'd0;
      q_nxt   = dividend;
      rem_nxt = '0;
      dv_nxt  = divisor;
    end else if (run_r) begin
      if (trial[33]) begin
        rem_nxt = {rem_r[31:0], q_r[47]};
        q_nxt   = {q_r[46:0], 1'b0};
      end else begin
        rem_nxt = trial[32:0];
        q_nxt   = {q_r[46:0], 1'b1};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd47) begin
        run_nxt = 1'b0;
        done    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) run_r <= 1'b0;
    else run_r <= run_nxt;
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
  end

  assign quotient = q_nxt;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the instruction forecast monitor. Items are sent
// over the start/busy command port in random bursts. A local table model
// predicts every snapshot and table-full flag. A monitor compares each
// strobed result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import ifm_pkg::*;

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam logic       STAT_SNAPSHOT = 1'b0;
  localparam logic       STAT_FULL     = 1'b1;
  localparam int         DRAIN_CYCLES  = 1000;

  typedef struct packed {
    logic        status;
    logic [31:0] addr;
    logic [31:0] total;
    logic [47:0] fdelay;
    logic [47:0] mgap;
    logic        last;
  } report_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_operation;
  logic [31:0] in_code_address;
  logic [3:0]  in_instr_class;
  logic [47:0] in_cycle_now;
  logic        out_valid;
  logic        out_status;
  logic [31:0] out_entry_address;
  logic [31:0] out_exec_total;
  logic [47:0] out_first_delay;
  logic [47:0] out_mean_gap;
  logic        out_last_of_run;

  // Forecast table model
  logic        tbl_valid [TableEntries];
  logic [31:0] tbl_addr  [TableEntries];
  logic [3:0]  tbl_cls   [TableEntries];
  logic [47:0] tbl_ftime [TableEntries];
  logic [47:0] tbl_fgap  [TableEntries];
  logic [47:0] tbl_ltime [TableEntries];
  logic [47:0] tbl_gsum  [TableEntries];
  logic [31:0] tbl_cnt   [TableEntries];

  report_t     pending_reports[$];
  int          mismatches;
  int          burst_left;
  logic [47:0] clock_now;

  instruction_forecast_monitor DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_code_address   (in_code_address),
    .in_instr_class    (in_instr_class),
    .in_cycle_now      (in_cycle_now),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_entry_address (out_entry_address),
    .out_exec_total    (out_exec_total),
    .out_first_delay   (out_first_delay),
    .out_mean_gap      (out_mean_gap),
    .out_last_of_run   (out_last_of_run)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Apply one accepted item to the table model and queue its reports
  task automatic forecast_table_update(input logic [1:0] op, input logic [31:0] addr,
                                       input logic [3:0] cls, input logic [47:0] now);
    int          slot;
    int          n;
    logic [47:0] d;
    logic [48:0] s;
    report_t     r;
    slot = -1;
    n = 0;
    case (op)
      OP_FORECAST: begin
        for (int i = 0; i < TableEntries; i++)
          if (slot < 0 && tbl_valid[i] && tbl_addr[i] == addr) slot = i;
        if (slot < 0) begin
          for (int i = 0; i < TableEntries; i++)
            if (slot < 0 && !tbl_valid[i]) slot = i;
          if (slot < 0) begin
            r = '{STAT_FULL, addr, 32'd0, 48'd0, 48'd0, 1'b1};
            pending_reports.push_back(r);
            return;
          end
          tbl_valid[slot] = 1'b1;
          tbl_addr[slot]  = addr;
          tbl_cls[slot]   = cls;
        end
        tbl_ftime[slot] = now;
        tbl_fgap[slot]  = '0;
        tbl_ltime[slot] = '0;
        tbl_gsum[slot]  = '0;
        tbl_cnt[slot]   = '0;
      end
      OP_EXEC: begin
        for (int i = 0; i < TableEntries; i++) begin
          if (tbl_valid[i] && tbl_cls[i] == cls) begin
            if (tbl_fgap[i] == '0) begin
              tbl_fgap[i] = now - tbl_ftime[i] + 48'd1;
            end else begin
              d = now - tbl_ltime[i] + 48'd1;
              s = {1'b0, tbl_gsum[i]} + {1'b0, d};
              tbl_gsum[i] = s[48] ? MAX48 : s[47:0];
            end
            tbl_ltime[i] = now;
            if (tbl_cnt[i] != MAX32) tbl_cnt[i] = tbl_cnt[i] + 32'd1;
          end
        end
      end
      OP_TERM: begin
        for (int i = 0; i < TableEntries; i++) begin
          if (n < MaxResults && tbl_valid[i] && tbl_cls[i] == cls) begin
            r = '{STAT_SNAPSHOT, tbl_addr[i], tbl_cnt[i], tbl_fgap[i],
                  (tbl_cnt[i] == 0) ? 48'd0 : tbl_gsum[i] / {16'd0, tbl_cnt[i]}, 1'b0};
            pending_reports.push_back(r);
            n++;
          end
        end
        if (n > 0) pending_reports[pending_reports.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Send one item; start stays high so a following item can go back to back
  task automatic send_item(input logic [1:0] op, input logic [31:0] addr,
                           input logic [3:0] cls, input logic [47:0] now);
    @(negedge clk);
    start           <= 1'b1;
    in_operation    <= op;
    in_code_address <= addr;
    in_instr_class  <= cls;
    in_cycle_now    <= now;
    do @(posedge clk); while (busy);
    forecast_table_update(op, addr, cls, now);
  endtask

  task automatic idle_cycles(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Bursty sender: after each transfer maybe pause
  task automatic send_bursty(input logic [1:0] op, input logic [31:0] addr,
                             input logic [3:0] cls, input logic [47:0] now);
    send_item(op, addr, cls, now);
    if (burst_left == 0) begin
      idle_cycles($urandom_range(0, 40));
      burst_left = $urandom_range(1, 10);
    end else begin
      burst_left--;
    end
  endtask

  // Result monitor
  always @(posedge clk) begin
    report_t e;
    if (rst_n && out_valid) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: address %h status %0d", out_entry_address, out_status);
        mismatches++;
      end else begin
        e = pending_reports.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_status);
          mismatches++;
        end
        if (out_entry_address !== e.addr) begin
          $error("entry_address: expected %h, actual %h", e.addr, out_entry_address);
          mismatches++;
        end
        if (out_exec_total !== e.total) begin
          $error("exec_total: expected %0d, actual %0d", e.total, out_exec_total);
          mismatches++;
        end
        if (out_first_delay !== e.fdelay) begin
          $error("first_delay: expected %h, actual %h", e.fdelay, out_first_delay);
          mismatches++;
        end
        if (out_mean_gap !== e.mgap) begin
          $error("mean_gap: expected %h, actual %h", e.mgap, out_mean_gap);
          mismatches++;
        end
        if (out_last_of_run !== e.last) begin
          $error("last_of_run: expected %0d, actual %0d", e.last, out_last_of_run);
          mismatches++;
        end
      end
    end
  end

  // Extremes of address, time and saturation, wrapped delay, kept class
  task automatic test_extremes();
    send_bursty(OP_FORECAST, 32'h0000_0000, 4'd0, 48'd0);
    send_bursty(OP_FORECAST, 32'hFFFF_FFFF, 4'd15, MAX48);
    send_bursty(OP_EXEC, 32'h0, 4'd0, 48'd1);
    send_bursty(OP_EXEC, 32'h0, 4'd0, MAX48);
    send_bursty(OP_EXEC, 32'h0, 4'd0, MAX48 - 48'd1);
    send_bursty(OP_TERM, 32'h0, 4'd0, 48'd10);
    // first delay wraps to zero, so the next execution sets it again
    send_bursty(OP_EXEC, 32'h0, 4'd15, MAX48 - 48'd1);
    send_bursty(OP_TERM, 32'h0, 4'd15, 48'd0);
    send_bursty(OP_EXEC, 32'h0, 4'd15, 48'd5);
    send_bursty(OP_TERM, 32'h0, 4'd15, 48'd6);
    // re-forecast keeps class 15 but clears counters
    send_bursty(OP_FORECAST, 32'hFFFF_FFFF, 4'd3, 48'h8000_0000_0000);
    send_bursty(OP_EXEC, 32'h0, 4'd3, 48'h8000_0000_0100);
    send_bursty(OP_TERM, 32'h0, 4'd15, 48'd0);
    send_bursty(OP_UNUSED, 32'hA5A5_5A5A, 4'd15, MAX48);
    send_bursty(OP_TERM, 32'h0, 4'd7, 48'd0);
  endtask

  // Fill the table, then overflow it
  task automatic test_table_full();
    for (int i = 2; i < TableEntries; i++)
      send_bursty(OP_FORECAST, $urandom, (i < 9) ? 4'd5 : 4'($urandom), 48'd1000);
    send_bursty(OP_FORECAST, 32'h5555_AAAA, 4'd5, 48'd1000);
    send_bursty(OP_TERM, 32'h0, 4'd5, 48'd1000);
  endtask

  task automatic test_random();
    int          pick;
    logic [1:0]  op;
    logic [31:0] addr;
    logic [3:0]  cls;
    for (int k = 0; k < 330; k++) begin
      pick = $urandom_range(0, 99);
      op = (pick < 25) ? OP_FORECAST : (pick < 70) ? OP_EXEC :
           (pick < 95) ? OP_TERM : OP_UNUSED;
      addr = ($urandom_range(0, 99) < 80) ? tbl_addr[$urandom_range(0, TableEntries - 1)]
                                          : 32'($urandom);
      cls = ($urandom_range(0, 99) < 75) ? tbl_cls[$urandom_range(0, TableEntries - 1)]
                                         : 4'($urandom);
      if ($urandom_range(0, 99) < 10)
        clock_now = {16'($urandom), 32'($urandom)};
      else
        clock_now = clock_now + 48'($urandom_range(0, 2000));
      send_bursty(op, addr, cls, clock_now);
    end
  endtask

  initial begin
    int waited;
    mismatches      = 0;
    burst_left      = 3;
    clock_now       = 48'd5000;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_operation    = OP_FORECAST;
    in_code_address = '0;
    in_instr_class  = '0;
    in_cycle_now    = '0;
    for (int i = 0; i < TableEntries; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_addr[i]  = '0;
      tbl_cls[i]   = '0;
      tbl_ftime[i] = '0;
      tbl_fgap[i]  = '0;
      tbl_ltime[i] = '0;
      tbl_gsum[i]  = '0;
      tbl_cnt[i]   = '0;
    end
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_extremes();
    test_table_full();
    test_random();
    idle_cycles(0);

    // drain outstanding reports
    waited = 0;
    while (pending_reports.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("tb passed");
    end else begin
      if (pending_reports.size() != 0)
        $error("%0d expected results never arrived", pending_reports.size());
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
